// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define BMPX_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Signal holds its value in the cycle after the condition.
`define BMPX_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("assertion failed: value changed while held");

`endif

// File: rtl/core/bmpx_pkg.sv
`timescale 1ns / 1ps

package bmpx_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned MaxWidth        = 4096;
  localparam int unsigned OutFifoDepth    = 4;
  localparam int unsigned FifoPtrW        = $clog2(OutFifoDepth);
  localparam int unsigned FifoCntW        = $clog2(OutFifoDepth + 1);
  localparam int unsigned WidthW          = 13;
  localparam int unsigned ByteW           = 14;

  typedef enum logic [1:0] {
    Depth1  = 2'd0,
    Depth4  = 2'd1,
    Depth8  = 2'd2,
    Depth24 = 2'd3
  } depth_e;

  typedef enum logic {
    CfgColorDepth = 1'b0,
    CfgImageWidth = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  idx;
    logic        direct;
    logic [23:0] rgb;
    logic        last;
    logic        eor;
  } pix_req_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        last;
    logic        eor;
  } pix_t;

endpackage

// File: rtl/core/bmpx_palette.sv
`timescale 1ns / 1ps

module bmpx_palette #(
  parameter int unsigned PaletteDepth = bmpx_pkg::PaletteDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [7:0]         waddr_i,
  input  logic [23:0]        wdata_i,
  input  logic               req_valid_i,
  input  bmpx_pkg::pix_req_t req_i,
  output logic               rsp_valid_o,
  output bmpx_pkg::pix_t     rsp_o
);
  import bmpx_pkg::*;

  localparam int unsigned AddrW = $clog2(PaletteDepth);

  logic [23:0] mem [PaletteDepth];
  logic [23:0] rdata_q;
  logic        valid_q;
  logic        direct_q;
  logic        black_q;
  logic [23:0] rgb_q;
  logic        last_q;
  logic        eor_q;
  logic        wr_ok;
  logic        rd_ok;

  assign wr_ok = 32'(waddr_i) < PaletteDepth;
  assign rd_ok = 32'(req_i.idx) < PaletteDepth;

  // A read in the same cycle as a write returns the old entry.
  always_ff @(posedge clk_i) begin
    if (we_i && wr_ok) begin
      mem[waddr_i[AddrW-1:0]] <= wdata_i;
    end
    if (req_valid_i) begin
      rdata_q <= mem[req_i.idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      direct_q <= req_i.direct;
      black_q  <= !rd_ok;
      rgb_q    <= req_i.rgb;
      last_q   <= req_i.last;
      eor_q    <= req_i.eor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_valid_i;
    end
  end

  assign rsp_valid_o = valid_q;
  assign rsp_o.rgb   = direct_q ? rgb_q : (black_q ? 24'd0 : rdata_q);
  assign rsp_o.last  = last_q;
  assign rsp_o.eor   = eor_q;

endmodule

// File: rtl/core/bmpx_out_fifo.sv
`timescale 1ns / 1ps

module bmpx_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bmpx_pkg::pix_t                data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output bmpx_pkg::pix_t                data_o,
  output logic [bmpx_pkg::FifoCntW-1:0] count_o
);
  import bmpx_pkg::*;

  pix_t                mem [OutFifoDepth];
  logic [FifoPtrW-1:0] wptr_q, wptr_d;
  logic [FifoPtrW-1:0] rptr_q, rptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem[rptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + FifoPtrW'(1);
    end
    if (pop) begin
      rptr_d = rptr_q + FifoPtrW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: rtl/core/bmp_palette_to_rgb_expander.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: index, R, G, B, byte; tuser: func
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: R, G, B; tlast; tuser: row end
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// Pixels leave at one per cycle, paced by the palette RAM read port, while m_axis_tready is high
// and the queue has room; the next byte or palette load is taken as a byte's last pixel issues.
// A byte's first pixel passes the issue registers, the palette read stage and the output queue.
// Reset selects 24-bit pixels, a width of 640 and row start; the palette is not cleared.
// Output stalls fill a four-entry queue, after which the issue stage and the input hold.

module bmp_palette_to_rgb_expander #(
  parameter int unsigned PaletteDepth = bmpx_pkg::PaletteDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // entry_index, red_in, green_in, blue_in, data_byte
  input  logic                s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // red, green, blue
  output logic                m_axis_tlast,
  output logic                m_axis_tuser,  // end_of_row
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  bmpx_pkg::cfg_reg_e  cfg_index_i,
  input  logic [12:0]         cfg_data_i
);
  import bmpx_pkg::*;

  depth_e              depth_q, depth_d;
  logic [WidthW-1:0]   width_q, width_d;
  logic [ByteW-1:0]    byte_q, byte_d;
  logic [WidthW-1:0]   rowpix_q, rowpix_d;
  logic [15:0]         held_q, held_d;
  logic [1:0]          heldcnt_q, heldcnt_d;

  logic [3:0]          icnt_q, icnt_d;
  logic [7:0]          ishift_q, ishift_d;
  logic [WidthW-1:0]   ipix_q, ipix_d;
  logic                idirect_q, idirect_d;
  logic [23:0]         irgb_q, irgb_d;

  logic                cfg_acc;
  logic                in_acc;
  logic                in_func;
  logic [7:0]          in_byte;
  logic [WidthW-1:0]   w_eff;
  logic [17:0]         row_bits;
  logic [17:0]         row_sum;
  logic [ByteW-1:0]    row_len;
  logic [ByteW:0]      byte_inc;
  logic                in_row;
  logic [WidthW-1:0]   rem;
  logic [3:0]          ppb;
  logic [3:0]          npix;
  logic [23:0]         direct_rgb;

  logic                issue_fire;
  logic                credit_ok;
  pix_req_t            req;
  logic                rsp_valid;
  pix_t                rsp;
  pix_t                head;
  logic [FifoCntW-1:0] fifo_cnt;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign in_func     = s_axis_tuser;
  assign in_byte     = s_axis_tdata[39:32];

  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
  end

  always_comb begin
    unique case (depth_q)
      Depth1:  row_bits = 18'(w_eff);
      Depth4:  row_bits = 18'(w_eff) << 2;
      Depth8:  row_bits = 18'(w_eff) << 3;
      Depth24: row_bits = (18'(w_eff) << 4) + (18'(w_eff) << 3);
      default: row_bits = 18'(w_eff);
    endcase
  end

  assign row_sum  = row_bits + 18'd31;
  assign row_len  = {row_sum[16:5], 2'b00};
  assign byte_inc = {1'b0, byte_q} + (ByteW + 1)'(1);

  assign in_row     = rowpix_q < w_eff;
  assign rem        = w_eff - rowpix_q;
  assign direct_rgb = {in_byte, held_q[15:8], held_q[7:0]};

  always_comb begin
    unique case (depth_q)
      Depth1:  ppb = 4'd8;
      Depth4:  ppb = 4'd2;
      Depth8:  ppb = 4'd1;
      Depth24: ppb = (heldcnt_q >= 2'd2) ? 4'd1 : 4'd0;
      default: ppb = 4'd0;
    endcase
  end

  always_comb begin
    if (!in_row) begin
      npix = 4'd0;
    end else if (rem < WidthW'(ppb)) begin
      npix = rem[3:0];
    end else begin
      npix = ppb;
    end
  end

  assign credit_ok = ((FifoCntW + 1)'(fifo_cnt) + (FifoCntW + 1)'(rsp_valid))
                     < (FifoCntW + 1)'(OutFifoDepth);
  assign issue_fire    = (icnt_q != 4'd0) && credit_ok;
  assign s_axis_tready = (icnt_q == 4'd0) || ((icnt_q == 4'd1) && issue_fire);

  always_comb begin
    depth_d   = depth_q;
    width_d   = width_q;
    byte_d    = byte_q;
    rowpix_d  = rowpix_q;
    held_d    = held_q;
    heldcnt_d = heldcnt_q;
    if (cfg_acc) begin
      unique case (cfg_index_i)
        CfgColorDepth: depth_d = depth_e'(cfg_data_i[1:0]);
        CfgImageWidth: width_d = cfg_data_i;
        default:       depth_d = depth_q;
      endcase
      byte_d    = '0;
      rowpix_d  = '0;
      held_d    = '0;
      heldcnt_d = '0;
    end else if (in_acc && in_func) begin
      rowpix_d = rowpix_q + WidthW'(npix);
      if (depth_q == Depth24 && in_row) begin
        if (heldcnt_q >= 2'd2) begin
          held_d    = '0;
          heldcnt_d = '0;
        end else begin
          held_d    = held_q | (16'(in_byte) << {heldcnt_q[0], 3'b000});
          heldcnt_d = heldcnt_q + 2'd1;
        end
      end
      byte_d = byte_inc[ByteW-1:0];
      if (byte_inc >= {1'b0, row_len}) begin
        byte_d    = '0;
        rowpix_d  = '0;
        held_d    = '0;
        heldcnt_d = '0;
      end
    end
  end

  always_comb begin
    icnt_d    = icnt_q;
    ishift_d  = ishift_q;
    ipix_d    = ipix_q;
    idirect_d = idirect_q;
    irgb_d    = irgb_q;
    if (issue_fire) begin
      icnt_d = icnt_q - 4'd1;
      ipix_d = ipix_q + WidthW'(1);
      unique case (depth_q)
        Depth1:  ishift_d = {ishift_q[6:0], 1'b0};
        Depth4:  ishift_d = {ishift_q[3:0], 4'b0000};
        default: ishift_d = ishift_q;
      endcase
    end
    if (in_acc && in_func) begin
      icnt_d    = npix;
      ishift_d  = in_byte;
      ipix_d    = rowpix_q;
      idirect_d = depth_q == Depth24;
      irgb_d    = direct_rgb;
    end
  end

  always_comb begin
    unique case (depth_q)
      Depth1:  req.idx = {7'd0, ishift_q[7]};
      Depth4:  req.idx = {4'd0, ishift_q[7:4]};
      default: req.idx = ishift_q;
    endcase
    req.direct = idirect_q;
    req.rgb    = irgb_q;
    req.last   = icnt_q == 4'd1;
    req.eor    = ipix_q == (w_eff - WidthW'(1));
  end

  always_ff @(posedge clk_i) begin
    ishift_q  <= ishift_d;
    ipix_q    <= ipix_d;
    idirect_q <= idirect_d;
    irgb_q    <= irgb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= Depth24;
      width_q   <= WidthW'(640);
      byte_q    <= '0;
      rowpix_q  <= '0;
      held_q    <= '0;
      heldcnt_q <= '0;
      icnt_q    <= '0;
    end else begin
      depth_q   <= depth_d;
      width_q   <= width_d;
      byte_q    <= byte_d;
      rowpix_q  <= rowpix_d;
      held_q    <= held_d;
      heldcnt_q <= heldcnt_d;
      icnt_q    <= icnt_d;
    end
  end

  bmpx_palette #(
    .PaletteDepth(PaletteDepth)
  ) u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (in_acc && !in_func),
    .waddr_i    (s_axis_tdata[7:0]),
    .wdata_i    ({s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]}),
    .req_valid_i(issue_fire),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp)
  );

  bmpx_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rsp_valid),
    .data_i (rsp),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (head),
    .count_o(fifo_cnt)
  );

  assign m_axis_tdata = {head.rgb[7:0], head.rgb[15:8], head.rgb[23:16]};
  assign m_axis_tlast = head.last;
  assign m_axis_tuser = head.eor;

endmodule

// File: rtl/core/bmpx_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmpx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser,
  input logic        cfg_ready_o
);

  // A pixel that ends its row is always the last pixel its byte produces.
  `BMPX_ASSERT(a_eor_is_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)

  // No result can be pending in the first cycle after reset.
  `BMPX_ASSERT(a_idle_after_reset, clk_i, rst_ni, !$past(rst_ni) |-> !m_axis_tvalid)

  `BMPX_ASSERT(a_cfg_always_ready, clk_i, rst_ni, cfg_ready_o)

  `BMPX_ASSERT(a_valid_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)

  `BMPX_ASSERT_HOLD(a_data_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tdata)

endmodule

bind bmp_palette_to_rgb_expander bmpx_checker u_bmpx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser),
  .cfg_ready_o  (cfg_ready_o)
);

// File: sim/bmp_palette_to_rgb_expander_tb.sv
`timescale 1ns / 1ps

module bmp_palette_to_rgb_expander_tb;
  import bmpx_pkg::*;

  localparam bit FuncPalette = 1'b0;
  localparam bit FuncData    = 1'b1;
  localparam int TailCycles  = 16;
  localparam int HoldCycles  = 150;
  localparam int RandomItems = 20;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
    logic       end_of_row;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = CfgColorDepth;
  logic [12:0] cfg_data_i = '0;

  // Expected pixels and the mirror of the block's state.
  pixel_t      pending_pixels[$];
  logic [23:0] palette_rgb[256];
  depth_e      depth_cfg = Depth24;
  logic [12:0] width_cfg = 13'd640;
  int          byte_pos = 0;
  int          pixel_pos = 0;
  logic [15:0] held_bytes = '0;
  int          held_count = 0;

  int          mismatch_count = 0;
  int          items_sent = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          stall_left = 0;
  int          hold_left = 0;

  always #2 clk_i = ~clk_i;

  bmp_palette_to_rgb_expander DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic int clamp_width(logic [12:0] w);
    if (w == 0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return w;
  endfunction

  function automatic int row_length(int w, depth_e d);
    int bpp;
    case (d)
      Depth1:  bpp = 1;
      Depth4:  bpp = 4;
      Depth8:  bpp = 8;
      default: bpp = 24;
    endcase
    return ((w * bpp + 31) / 32) * 4;
  endfunction

  function void restart_row();
    byte_pos   = 0;
    pixel_pos  = 0;
    held_bytes = '0;
    held_count = 0;
  endfunction

  function void queue_pixel(logic [23:0] rgb, int w);
    pixel_t px;
    px.red         = rgb[23:16];
    px.green       = rgb[15:8];
    px.blue        = rgb[7:0];
    px.last_of_run = 1'b0;
    px.end_of_row  = (pixel_pos == w - 1);
    pending_pixels.push_back(px);
    pixel_pos++;
  endfunction

  function void expand_request(bit func, logic [7:0] entry, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic [7:0] data);
    int w;
    int n;
    n = 0;
    if (func == FuncPalette) begin
      palette_rgb[entry] = {r, g, b};
      return;
    end
    w = clamp_width(width_cfg);
    case (depth_cfg)
      Depth1: begin
        for (int k = 7; k >= 0; k--) begin
          if (pixel_pos < w) begin
            queue_pixel(palette_rgb[{7'd0, data[k]}], w);
            n++;
          end
        end
      end
      Depth4: begin
        if (pixel_pos < w) begin
          queue_pixel(palette_rgb[{4'd0, data[7:4]}], w);
          n++;
        end
        if (pixel_pos < w) begin
          queue_pixel(palette_rgb[{4'd0, data[3:0]}], w);
          n++;
        end
      end
      Depth8: begin
        if (pixel_pos < w) begin
          queue_pixel(palette_rgb[data], w);
          n++;
        end
      end
      default: begin
        if (pixel_pos < w) begin
          if (held_count >= 2) begin
            queue_pixel({data, held_bytes[15:8], held_bytes[7:0]}, w);
            n++;
            held_bytes = '0;
            held_count = 0;
          end else begin
            if (held_count == 0) held_bytes[7:0] = data;
            else held_bytes[15:8] = data;
            held_count++;
          end
        end
      end
    endcase
    if (n > 0) pending_pixels[$].last_of_run = 1'b1;
    byte_pos++;
    if (byte_pos >= row_length(w, depth_cfg)) restart_row();
  endfunction

  function void check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %06h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        check_field("red", exp_px.red, m_axis_tdata[7:0]);
        check_field("green", exp_px.green, m_axis_tdata[15:8]);
        check_field("blue", exp_px.blue, m_axis_tdata[23:16]);
        check_field("last_of_run", exp_px.last_of_run, m_axis_tlast);
        check_field("end_of_row", exp_px.end_of_row, m_axis_tuser);
      end
      stall_left = rx_idle ? $urandom_range(0, 10) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_request(bit func, logic [7:0] entry, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic [7:0] data);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {data, b, g, r, entry};
    s_axis_tuser  = func;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expand_request(func, entry, r, g, b, data);
    items_sent++;
  endtask

  task automatic send_pixel_byte(logic [7:0] data);
    send_request(FuncData, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), data);
  endtask

  task automatic load_entry(logic [7:0] entry, logic [23:0] rgb);
    send_request(FuncPalette, entry, rgb[23:16], rgb[15:8], rgb[7:0], 8'($urandom));
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e reg_index, logic [12:0] value);
    wait_results();
    @(negedge clk_i);
    cfg_index_i = reg_index;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (reg_index == CfgColorDepth) depth_cfg = depth_e'(value[1:0]);
    else width_cfg = value;
    restart_row();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_mode(depth_e d, logic [12:0] w);
    write_register(CfgColorDepth, {11'($urandom), d});
    write_register(CfgImageWidth, w);
  endtask

  task automatic test_palette_fill();
    load_entry(8'd0, 24'h000000);
    load_entry(8'd1, 24'hffffff);
    for (int i = 2; i < 256; i++) load_entry(8'(i), 24'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_pixel_byte(8'h00);
    send_pixel_byte(8'hff);
    send_pixel_byte(8'h5a);
    send_pixel_byte(8'hc3);
    send_pixel_byte(8'h3c);
  endtask

  task automatic test_one_bit();
    set_mode(Depth1, 13'd10);
    send_pixel_byte(8'h80);
    send_pixel_byte(8'h7f);
    send_pixel_byte(8'hff);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'h55);
  endtask

  task automatic test_four_bit();
    set_mode(Depth4, 13'd3);
    send_pixel_byte(8'hf0);
    load_entry(8'd15, 24'h00ff00);
    send_pixel_byte(8'h0f);
    send_pixel_byte(8'haa);
    send_pixel_byte(8'h11);
  endtask

  task automatic test_eight_bit();
    set_mode(Depth8, 13'd1);
    send_pixel_byte(8'hff);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'h80);
    send_pixel_byte(8'h01);
    send_pixel_byte(8'h00);
  endtask

  task automatic test_width_limits();
    write_register(CfgImageWidth, 13'd0);
    send_pixel_byte(8'h12);
    send_pixel_byte(8'h34);
    set_mode(Depth1, 13'd8191);
    send_pixel_byte(8'ha5);
    write_register(CfgImageWidth, 13'd4096);
    send_pixel_byte(8'h3c);
  endtask

  task automatic test_backpressure();
    set_mode(Depth1, 13'd64);
    tx_idle = 1'b0;
    hold_left = HoldCycles;
    for (int i = 0; i < 12; i++) send_pixel_byte(8'($urandom));
    wait_results();
    tx_idle = 1'b1;
    for (int i = 0; i < 6; i++) send_pixel_byte(8'($urandom));
  endtask

  task automatic test_random_rows();
    int start;
    int w;
    int nbytes;
    depth_e d;
    logic [12:0] wcfg;
    logic [7:0] data;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      d = depth_e'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
        0:       wcfg = 13'd0;
        1:       wcfg = 13'd4096;
        2:       wcfg = 13'($urandom_range(4097, 8191));
        3:       wcfg = 13'd1;
        default: wcfg = 13'($urandom_range(1, 40));
      endcase
      set_mode(d, wcfg);
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      w = clamp_width(wcfg);
      nbytes = row_length(w, d) * $urandom_range(1, 2) + $urandom_range(0, 3);
      if (nbytes > 30) nbytes = $urandom_range(10, 30);
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 7) == 0) load_entry(8'($urandom), 24'($urandom));
        case ($urandom_range(0, 7))
          0:       data = 8'h00;
          1:       data = 8'hff;
          default: data = 8'($urandom);
        endcase
        send_pixel_byte(data);
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_palette_fill();
    test_reset_defaults();
    test_one_bit();
    test_four_bit();
    test_eight_bit();
    test_width_limits();
    test_backpressure();
    test_random_rows();
    wait_results();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: bmp_palette_to_rgb_expander.f
+incdir+rtl/core
rtl/core/bmpx_pkg.sv
rtl/core/bmpx_palette.sv
rtl/core/bmpx_out_fifo.sv
rtl/core/bmp_palette_to_rgb_expander.sv
rtl/core/bmpx_checker.sv
sim/bmp_palette_to_rgb_expander_tb.sv
